FILE: rtl/vrs_pkg.sv
`timescale 1ns / 1ps
package vrs_pkg;

  // Action codes as they arrive on the input stream
  localparam logic [2:0] ACT_PUSH = 3'd0;
  localparam logic [2:0] ACT_POP  = 3'd1;
  localparam logic [2:0] ACT_PEEK = 3'd2;
  localparam logic [2:0] ACT_READ = 3'd3;
  localparam logic [2:0] ACT_ZERO = 3'd4;

  // Decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_READ,
    OP_ZERO,
    OP_NOP
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  // One classified command
  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last_byte;
    logic [30:0] tag;
    logic [11:0] read_address;
    logic        rd_ok;        // read_address lies inside the byte memory
  } cmd_t;

  // One result beat
  typedef struct packed {
    status_t     status;
    logic [11:0] record_address;
    logic [11:0] record_size;
    logic [30:0] tag_out;
    logic [7:0]  read_data;
    logic [6:0]  record_count;
  } res_t;

endpackage

FILE: rtl/vrs_front.sv
`timescale 1ns / 1ps
module vrs_front #(
  parameter int MEM_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [55:0]         s_axis_tdata,  // data_byte, tag, read_address, pad
  input  logic [3:0]          s_axis_tuser,  // action, byte_valid
  input  logic                s_axis_tlast,
  input  logic                clearing,
  output logic                cmd_valid,
  output vrs_pkg::cmd_t       cmd,
  input  logic                cmd_take
);
  import vrs_pkg::*;

  cmd_t       dec;
  cmd_t       q_buf [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       push;

  // Classify the incoming beat
  always_comb begin
    dec.data_byte    = s_axis_tdata[7:0];
    dec.tag          = s_axis_tdata[38:8];
    dec.read_address = s_axis_tdata[50:39];
    dec.byte_valid   = s_axis_tuser[3];
    dec.last_byte    = s_axis_tlast;
    dec.rd_ok        = ({5'd0, s_axis_tdata[50:39]} < 17'(MEM_BYTES));
    unique case (s_axis_tuser[2:0])
      ACT_PUSH: dec.op = OP_PUSH;
      ACT_POP:  dec.op = OP_POP;
      ACT_PEEK: dec.op = OP_PEEK;
      ACT_READ: dec.op = OP_READ;
      ACT_ZERO: dec.op = OP_ZERO;
      default:  dec.op = OP_NOP;
    endcase
  end

  // Two-entry command queue toward the back end
  assign s_axis_tready = (q_cnt != 2'd2) && !clearing;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid     = (q_cnt != 2'd0);
  assign cmd           = q_buf[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_buf[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_take})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

endmodule

FILE: rtl/vrs_back.sv
`timescale 1ns / 1ps
module vrs_back #(
  parameter int MEM_BYTES   = 4096,
  parameter int MAX_RECORDS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  vrs_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          clearing,
  output logic          res_valid,
  output vrs_pkg::res_t res,
  input  logic          res_ready
);
  import vrs_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int IW = $clog2(MAX_RECORDS);
  localparam logic [AW:0]   MEM_LIM  = (AW + 1)'(MEM_BYTES);
  localparam logic [AW-1:0] LAST_ADR = AW'(MEM_BYTES - 1);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_RECORDS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_ZSIZE,
    S_ZERO,
    S_ZEND
  } state_t;

  state_t        state;
  logic [AW-1:0] top;
  logic [AW-1:0] pend;
  logic          pend_ovf;
  logic [CW-1:0] count;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] zaddr;
  logic [AW:0]   zrem;
  op_t           cur_op;
  logic          rd_ok_q;

  // Memories and their registered read data
  logic [7:0]    byte_mem [MEM_BYTES];
  logic [AW-1:0] size_mem [MAX_RECORDS];
  logic [30:0]   tag_mem  [MAX_RECORDS];
  logic [7:0]    rd_q;
  logic [AW-1:0] size_q;
  logic [30:0]   tag_q;

  // Combinational controls
  logic          out_free;
  logic [AW:0]   addr_sum;
  logic          byte_ok;
  logic          over;
  logic          wr_byte;
  logic          ovf_n;
  logic [AW-1:0] pend_n;
  logic [AW:0]   commit_sum;
  logic          reject;
  logic          commit;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] cnt_inc;
  logic [AW-1:0] new_top;
  logic [AW:0]   avail;
  logic [AW:0]   sz_ext;
  logic [AW:0]   zlen;
  logic [16:0]   ra_w;
  logic [16:0]   top_w;
  logic [16:0]   sz_w;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_re;
  logic          tab_we;
  logic          tab_re;
  logic [IW-1:0] tab_addr;
  logic          load;
  res_t          res_n;

  assign clearing  = (state == S_CLEAR);
  assign out_free  = !res_valid || res_ready;
  assign cmd_take  = (state == S_IDLE) && cmd_valid && out_free;
  assign cnt_dec   = count - CW'(1);
  assign cnt_inc   = count + CW'(1);
  assign ra_w      = {5'd0, cmd.read_address};

  // Push arithmetic: byte placement, overflow and commit check
  always_comb begin
    addr_sum   = {1'b0, top} + {1'b0, pend};
    byte_ok    = cmd.byte_valid && !pend_ovf;
    over       = (addr_sum + (AW + 1)'(1)) >= MEM_LIM;
    wr_byte    = byte_ok && !over;
    ovf_n      = pend_ovf || (byte_ok && over);
    pend_n     = pend + AW'(wr_byte);
    commit_sum = {1'b0, top} + {1'b0, pend_n};
    reject     = ovf_n || (commit_sum >= MEM_LIM) || (count >= MAX_CNT);
    commit     = cmd.last_byte && !reject;
  end

  // Pop/peek and zero-last lengths from the table read
  always_comb begin
    new_top = (size_q > top) ? '0 : top - size_q;
    avail   = MEM_LIM - {1'b0, top};
    sz_ext  = {1'b0, size_q};
    zlen    = (sz_ext < avail) ? sz_ext : avail;
    sz_w    = 17'(size_q);
    top_w   = (cur_op == OP_POP) ? 17'(new_top) : 17'(new_top);
  end

  // Memory port steering
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = zaddr;
    mem_wd   = 8'd0;
    mem_re   = 1'b0;
    tab_we   = 1'b0;
    tab_re   = 1'b0;
    tab_addr = count[IW-1:0];
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
      end
      S_IDLE: begin
        if (cmd_take) begin
          case (cmd.op)
            OP_PUSH: begin
              mem_we = wr_byte;
              mem_wa = addr_sum[AW-1:0];
              mem_wd = cmd.data_byte;
              tab_we = commit;
            end
            OP_POP, OP_PEEK: begin
              tab_re   = (count != '0);
              tab_addr = cnt_dec[IW-1:0];
            end
            OP_READ: mem_re = 1'b1;
            OP_ZERO: tab_re = (count < MAX_CNT);
            default: ;
          endcase
        end
      end
      S_ZERO: mem_we = 1'b1;
      default: ;
    endcase
  end

  // Result formation
  always_comb begin
    load                 = 1'b0;
    res_n.status         = STAT_OK;
    res_n.record_address = 12'd0;
    res_n.record_size    = 12'd0;
    res_n.tag_out        = 31'd0;
    res_n.read_data      = 8'd0;
    res_n.record_count   = 7'(count);
    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          case (cmd.op)
            OP_PUSH: begin
              load = 1'b1;
              if (cmd.last_byte) begin
                res_n.status = reject ? STAT_OVERFLOW : STAT_OK;
              end else begin
                res_n.status = ovf_n ? STAT_OVERFLOW : STAT_OK;
              end
              res_n.record_count = commit ? 7'(cnt_inc) : 7'(count);
            end
            OP_POP, OP_PEEK: begin
              load         = (count == '0);
              res_n.status = STAT_EMPTY;
            end
            OP_READ: load = 1'b0;
            OP_ZERO: load = (count >= MAX_CNT);
            default: load = 1'b1;
          endcase
        end
      end
      S_FETCH: begin
        load = out_free;
        if (cur_op == OP_READ) begin
          res_n.read_data = rd_ok_q ? rd_q : 8'd0;
        end else begin
          res_n.record_address = top_w[11:0];
          res_n.record_size    = sz_w[11:0];
          res_n.tag_out        = tag_q;
          if (cur_op == OP_POP) begin
            res_n.record_count = 7'(cnt_dec);
          end
        end
      end
      S_ZEND: load = out_free;
      default: ;
    endcase
  end

  // Byte memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= byte_mem[ra_w[AW-1:0]];
    end
  end

  // Record tables
  always_ff @(posedge clk) begin
    if (tab_we) begin
      size_mem[tab_addr] <= pend_n;
      tag_mem[tab_addr]  <= cmd.tag;
    end
    if (tab_re) begin
      size_q <= size_mem[tab_addr];
      tag_q  <= tag_mem[tab_addr];
    end
  end

  // Sequencer, stack state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      top       <= '0;
      pend      <= '0;
      pend_ovf  <= 1'b0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        res       <= res_n;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_take) begin
            cur_op  <= cmd.op;
            rd_ok_q <= cmd.rd_ok;
            case (cmd.op)
              OP_PUSH: begin
                if (cmd.last_byte) begin
                  pend     <= '0;
                  pend_ovf <= 1'b0;
                  if (!reject) begin
                    top   <= commit_sum[AW-1:0];
                    count <= cnt_inc;
                  end
                end else begin
                  pend     <= pend_n;
                  pend_ovf <= ovf_n;
                end
              end
              OP_POP, OP_PEEK: begin
                if (count != '0) begin
                  state <= S_FETCH;
                end
              end
              OP_READ: state <= S_FETCH;
              OP_ZERO: begin
                if (count < MAX_CNT) begin
                  state <= S_ZSIZE;
                end
              end
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          if (out_free) begin
            state <= S_IDLE;
            if (cur_op == OP_POP) begin
              top   <= new_top;
              count <= cnt_dec;
            end
          end
        end
        S_ZSIZE: begin
          zaddr <= top;
          zrem  <= zlen;
          state <= (zlen == '0) ? S_ZEND : S_ZERO;
        end
        S_ZERO: begin
          zaddr <= zaddr + AW'(1);
          zrem  <= zrem - (AW + 1)'(1);
          if (zrem == (AW + 1)'(1)) begin
            state <= S_ZEND;
          end
        end
        S_ZEND: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/variable_record_stack_core.sv
`timescale 1ns / 1ps
// Stack of variable-length byte records with a 31-bit tag each, held in a
// byte memory of MEM_BYTES bytes and a record table of MAX_RECORDS entries.
// One result beat comes back for every input beat, in order. A push beat, an
// unknown action, a pop or peek on an empty stack and a zero last with a full
// table are answered from the idle state; pop, peek and byte read otherwise go
// through a fetch state, as the record table and byte memory have a registered
// read port, and zero last through size, zero and end states, as the clear goes
// through the single byte-memory write port. A two-entry command queue sits
// between the input classifier and the execution unit, and a result register
// sits on the output, so input beats are still taken while a result waits. After
// reset the byte memory is cleared one byte per cycle, s_axis_tready held low.
module variable_record_stack_core #(
  parameter int MEM_BYTES   = 4096,
  parameter int MAX_RECORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // data_byte[7:0], tag[38:8], read_address[50:39]
  input  logic [3:0]  s_axis_tuser,   // action[2:0], byte_valid[3]
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // record_address[11:0], record_size[23:12],
                                      // tag_out[54:24], read_data[62:55],
                                      // record_count[69:63]
  output logic [1:0]  m_axis_tuser    // status
);
  import vrs_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;
  logic clearing;
  res_t res;

  vrs_front #(
    .MEM_BYTES (MEM_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .clearing      (clearing),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  vrs_back #(
    .MEM_BYTES   (MEM_BYTES),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .clearing  (clearing),
    .res_valid (m_axis_tvalid),
    .res       (res),
    .res_ready (m_axis_tready)
  );

  // Output beat packing
  assign m_axis_tdata = {2'b00, res.record_count, res.read_data, res.tag_out,
                         res.record_size, res.record_address};
  assign m_axis_tuser = res.status;

endmodule

FILE: rtl/vrs_checker.sv
`timescale 1ns / 1ps
module vrs_checker #(
  parameter int MAX_RECORDS = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import vrs_pkg::*;

  // No result may be pending right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat valid after reset");

  // A stalled result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // Status code three is never produced
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("undefined status code");

  // Record count stays within the table
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> {25'd0, m_axis_tdata[69:63]} <= 32'(MAX_RECORDS))
    else $error("record count beyond table size");

  // An empty-stack result carries zero count and no record fields
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == STAT_EMPTY
      |-> m_axis_tdata[69:63] == 7'd0 && m_axis_tdata[54:0] == 55'd0)
    else $error("empty result with nonzero fields");

endmodule

bind variable_record_stack_core vrs_checker #(
  .MAX_RECORDS (MAX_RECORDS)
) u_vrs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
